[sv/svfc_pkg.sv]
`timescale 1ns / 1ps

package svfc_pkg;

    // Fixed internal word: signed 32 bits, sample fraction bits
    localparam int ACC_W  = 32;
    localparam int COEF_W = 16;
    localparam int PROD_W = ACC_W + COEF_W;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_MODE    = 3'd0,
        REG_STAGES  = 3'd1,
        REG_CUTOFF  = 3'd2,
        REG_DAMPING = 3'd3,
        REG_GAIN    = 3'd4
    } reg_index_t;

    // Response codes
    typedef enum logic [2:0] {
        MODE_LP     = 3'd0,
        MODE_HP     = 3'd1,
        MODE_BP     = 3'd2,
        MODE_NOTCH  = 3'd3,
        MODE_EQ     = 3'd4,
        MODE_BYPASS = 3'd5
    } mode_t;

    // Coefficient caps and reset values
    localparam logic [COEF_W-1:0] CUTOFF_CAP    = 16'd52429;
    localparam logic [COEF_W-1:0] DAMPING_CAP   = 16'd32768;
    localparam logic [COEF_W-1:0] CUTOFF_RESET  = 16'd45875;
    localparam logic [COEF_W-1:0] DAMPING_RESET = 16'd24543;
    localparam logic [COEF_W-1:0] GAIN_RESET    = 16'd4096;

    // Rounding shift that follows a product
    typedef enum logic [1:0] {
        SH_12 = 2'd0,
        SH_14 = 2'd1,
        SH_16 = 2'd2
    } shift_t;

    // Multiplier request from the sequencer
    typedef struct packed {
        logic   start;
        shift_t shift;
    } mul_req_t;

    // States of the stage sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_W_DAMP,
        ST_HP_SUB,
        ST_W_HP,
        ST_W_BP,
        ST_W_GAIN,
        ST_RESP,
        ST_FIN
    } state_t;

    // Saturating 32-bit add
    function automatic logic signed [ACC_W-1:0] sat_add32(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = 33'(a) + 33'(b);
        if (s > 33'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (s < -33'sd2147483648) begin
            return 32'sh80000000;
        end
        return s[ACC_W-1:0];
    endfunction

    // Saturating 32-bit subtract
    function automatic logic signed [ACC_W-1:0] sat_sub32(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = 33'(a) - 33'(b);
        if (s > 33'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (s < -33'sd2147483648) begin
            return 32'sh80000000;
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

[sv/state_variable_filter_cascade_core.sv]
`timescale 1ns / 1ps
// Cascaded state-variable filter, one bit-serial multiplier shared by all products.
// The products are made one after another by the shift-add multiplier (3 products per
// stage, 4 in eq mode); bypass skips the multiplier.
// A new sample is taken only when idle; the next sample is taken while a result waits.
// Reset (aresetn low, synchronous): configuration registers to defaults, filter memories to zero.
module state_variable_filter_cascade_core
    import svfc_pkg::*;
#(
    parameter int MAX_STAGES   = 2,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [2:0]                     cfg_index,
    input  logic [COEF_W-1:0]              cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_sample_out
);

    localparam int STG_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam logic [2:0] MAX_ST = 3'(MAX_STAGES);
    localparam longint SMP_MAX_L = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [ACC_W-1:0] SMP_MAX = SMP_MAX_L[ACC_W-1:0];
    localparam logic signed [ACC_W-1:0] SMP_MIN = -SMP_MAX - 32'sd1;

    // Configuration registers
    logic [2:0]        mode_reg;
    logic [1:0]        stage_count_reg;
    logic [COEF_W-1:0] cutoff_reg;
    logic [COEF_W-1:0] damping_reg;
    logic [COEF_W-1:0] gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_LP;
            stage_count_reg <= 2'd1;
            cutoff_reg      <= CUTOFF_RESET;
            damping_reg     <= DAMPING_RESET;
            gain_reg        <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODE:    mode_reg        <= cfg_wr_data[2:0];
                REG_STAGES:  stage_count_reg <= cfg_wr_data[1:0];
                REG_CUTOFF:  cutoff_reg      <= cfg_wr_data;
                REG_DAMPING: damping_reg     <= cfg_wr_data;
                REG_GAIN:    gain_reg        <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Effective settings: bad mode or stage count runs one lowpass stage (bypass follows mode_reg)
    logic              cfg_bad;
    logic [2:0]        mode_eff;
    logic [2:0]        run_stages;
    logic [COEF_W-1:0] fc;
    logic [COEF_W-1:0] dm;

    always_comb begin
        cfg_bad    = (mode_reg > MODE_BYPASS) || (stage_count_reg == 2'd0) ||
                     ({1'b0, stage_count_reg} > MAX_ST);
        mode_eff   = cfg_bad ? MODE_LP : mode_reg;
        run_stages = cfg_bad ? 3'd1 : {1'b0, stage_count_reg};
        fc         = (cutoff_reg > CUTOFF_CAP) ? CUTOFF_CAP : cutoff_reg;
        dm         = (damping_reg > DAMPING_CAP) ? DAMPING_CAP : damping_reg;
    end

    // Sequencer and datapath registers
    state_t                  state_reg, state_next;
    logic [2:0]              stage_reg, stage_next;
    logic signed [ACC_W-1:0] x_reg, x_next;
    logic signed [ACC_W-1:0] t_reg, t_next;
    logic signed [ACC_W-1:0] hp_reg, hp_next;
    logic signed [ACC_W-1:0] bp_reg, bp_next;
    logic signed [ACC_W-1:0] lp_reg, lp_next;
    logic signed [ACC_W-1:0] y_reg, y_next;
    logic                    m_valid_reg, m_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] m_sample_reg, m_sample_next;

    logic signed [ACC_W-1:0] band_mem_reg [MAX_STAGES];
    logic signed [ACC_W-1:0] low_mem_reg  [MAX_STAGES];
    logic                    mem_we;

    logic [STG_W-1:0]        stg_idx;
    logic signed [ACC_W-1:0] bm;
    logic signed [ACC_W-1:0] lm;

    // Shared multiplier
    mul_req_t                mul_req;
    logic signed [ACC_W-1:0] mul_a;
    logic [COEF_W-1:0]       mul_c;
    logic                    mul_done;
    logic signed [ACC_W-1:0] mul_res;

    svfc_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .op_a    (mul_a),
        .op_c    (mul_c),
        .done    (mul_done),
        .result  (mul_res)
    );

    assign stg_idx = stage_reg[STG_W-1:0];
    assign bm      = band_mem_reg[stg_idx];
    assign lm      = low_mem_reg[stg_idx];

    logic signed [ACC_W-1:0] hp_comb;
    logic signed [ACC_W-1:0] bp_comb;
    logic signed [ACC_W-1:0] lp_comb;
    logic signed [ACC_W-1:0] hl_sum;
    logic signed [ACC_W-1:0] resp;
    logic                    out_free;

    always_comb begin
        hp_comb  = sat_sub32(x_reg, t_reg);
        bp_comb  = sat_add32(mul_res, bm);
        lp_comb  = sat_add32(mul_res, lm);
        hl_sum   = sat_add32(hp_reg, lp_reg);
        out_free = !m_valid_reg || m_ready;
        case (mode_eff)
            MODE_HP:    resp = hp_reg;
            MODE_BP:    resp = bp_reg;
            MODE_NOTCH: resp = hl_sum;
            MODE_EQ:    resp = sat_add32(hl_sum, t_reg);
            default:    resp = lp_reg;
        endcase
    end

    // Next state and datapath control
    always_comb begin
        state_next    = state_reg;
        stage_next    = stage_reg;
        x_next        = x_reg;
        t_next        = t_reg;
        hp_next       = hp_reg;
        bp_next       = bp_reg;
        lp_next       = lp_reg;
        y_next        = y_reg;
        m_sample_next = m_sample_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        mem_we        = 1'b0;
        mul_req.start = 1'b0;
        mul_req.shift = SH_16;
        mul_a         = bm;
        mul_c         = fc;
        s_ready       = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    x_next = 32'(s_sample_in);
                    y_next = 32'(s_sample_in);
                    stage_next = 3'd0;
                    state_next = (mode_reg == MODE_BYPASS) ? ST_FIN : ST_START;
                end
            end
            // band memory times damping
            ST_START: begin
                mul_req.start = 1'b1;
                mul_req.shift = SH_14;
                mul_a         = bm;
                mul_c         = dm;
                state_next    = ST_W_DAMP;
            end
            ST_W_DAMP: begin
                if (mul_done) begin
                    t_next     = sat_add32(mul_res, lm);
                    state_next = ST_HP_SUB;
                end
            end
            // highpass, then highpass times cutoff
            ST_HP_SUB: begin
                hp_next       = hp_comb;
                mul_req.start = 1'b1;
                mul_req.shift = SH_16;
                mul_a         = hp_comb;
                mul_c         = fc;
                state_next    = ST_W_HP;
            end
            // bandpass, then bandpass times cutoff
            ST_W_HP: begin
                if (mul_done) begin
                    bp_next       = bp_comb;
                    mul_req.start = 1'b1;
                    mul_req.shift = SH_16;
                    mul_a         = bp_comb;
                    mul_c         = fc;
                    state_next    = ST_W_BP;
                end
            end
            // lowpass and memory update; eq needs the band gain product
            ST_W_BP: begin
                if (mul_done) begin
                    lp_next = lp_comb;
                    mem_we  = 1'b1;
                    if (mode_eff == MODE_EQ) begin
                        mul_req.start = 1'b1;
                        mul_req.shift = SH_12;
                        mul_a         = bp_reg;
                        mul_c         = gain_reg;
                        state_next    = ST_W_GAIN;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_W_GAIN: begin
                if (mul_done) begin
                    t_next     = mul_res;
                    state_next = ST_RESP;
                end
            end
            // stage response feeds the next stage or the output
            ST_RESP: begin
                if (stage_reg + 3'd1 < run_stages) begin
                    x_next     = resp;
                    stage_next = stage_reg + 3'd1;
                    state_next = ST_START;
                end else begin
                    y_next     = resp;
                    stage_next = 3'd0;
                    state_next = ST_FIN;
                end
            end
            // saturate to sample width into the output register
            ST_FIN: begin
                if (out_free) begin
                    if (y_reg > SMP_MAX) begin
                        m_sample_next = SMP_MAX[SAMPLE_WIDTH-1:0];
                    end else if (y_reg < SMP_MIN) begin
                        m_sample_next = SMP_MIN[SAMPLE_WIDTH-1:0];
                    end else begin
                        m_sample_next = y_reg[SAMPLE_WIDTH-1:0];
                    end
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            stage_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            stage_reg   <= stage_next;
            m_valid_reg <= m_valid_next;
        end
        x_reg        <= x_next;
        t_reg        <= t_next;
        hp_reg       <= hp_next;
        bp_reg       <= bp_next;
        lp_reg       <= lp_next;
        y_reg        <= y_next;
        m_sample_reg <= m_sample_next;
    end

    // Per-stage filter memories
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_STAGES; i++) begin
                band_mem_reg[i] <= '0;
                low_mem_reg[i]  <= '0;
            end
        end else if (mem_we) begin
            band_mem_reg[stg_idx] <= bp_reg;
            low_mem_reg[stg_idx]  <= lp_comb;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;

endmodule

[sv/svfc_serial_mul.sv]
`timescale 1ns / 1ps

// Bit-serial signed x unsigned multiplier, one coefficient bit per cycle,
// MSB first, followed by one round/saturate step. Result pulses done.
module svfc_serial_mul
    import svfc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mul_req_t                 req,
    input  logic signed [ACC_W-1:0]  op_a,
    input  logic [COEF_W-1:0]        op_c,
    output logic                     done,
    output logic signed [ACC_W-1:0]  result
);

    logic                     busy_reg, busy_next;
    logic                     rnd_reg, rnd_next;
    logic                     done_reg, done_next;
    logic [3:0]               cnt_reg, cnt_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0]  a_reg, a_next;
    logic [COEF_W-1:0]        c_reg, c_next;
    shift_t                   sh_reg, sh_next;
    logic signed [ACC_W-1:0]  res_reg, res_next;

    logic signed [PROD_W-1:0] rsum;
    logic signed [PROD_W-1:0] rshift;
    logic signed [ACC_W-1:0]  rsat;

    // Round half up, floor shift, saturate to 32 bits
    always_comb begin
        case (sh_reg)
            SH_12: begin
                rsum   = acc_reg + 48'sd2048;
                rshift = rsum >>> 12;
            end
            SH_14: begin
                rsum   = acc_reg + 48'sd8192;
                rshift = rsum >>> 14;
            end
            default: begin
                rsum   = acc_reg + 48'sd32768;
                rshift = rsum >>> 16;
            end
        endcase
        if (rshift > 48'sd2147483647) begin
            rsat = 32'sh7FFFFFFF;
        end else if (rshift < -48'sd2147483648) begin
            rsat = 32'sh80000000;
        end else begin
            rsat = rshift[ACC_W-1:0];
        end
    end

    // Shift-add sequence
    always_comb begin
        busy_next = busy_reg;
        rnd_next  = rnd_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        c_next    = c_reg;
        sh_next   = sh_reg;
        res_next  = res_reg;
        if (busy_reg) begin
            acc_next = (acc_reg <<< 1) + (c_reg[COEF_W-1] ? 48'(a_reg) : 48'sd0);
            c_next   = c_reg << 1;
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15) begin
                busy_next = 1'b0;
                rnd_next  = 1'b1;
            end
        end else if (rnd_reg) begin
            res_next  = rsat;
            done_next = 1'b1;
            rnd_next  = 1'b0;
        end else if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 4'd0;
            acc_next  = '0;
            a_next    = op_a;
            c_next    = op_c;
            sh_next   = req.shift;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            rnd_reg  <= rnd_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        c_reg   <= c_next;
        sh_reg  <= sh_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
